FILE: hdl/gca_pkg.sv
// Shared constants, register indexes and control/status types for the gradient animator.
`default_nettype none

package gca_pkg;

  // Color stop table
  localparam int MAX_STOPS     = 4;
  localparam int NUM_STOP_REGS = 4;
  localparam int STOP_REGS     = (MAX_STOPS < NUM_STOP_REGS) ? MAX_STOPS : NUM_STOP_REGS;
  localparam int STOP_IDX_W    = $clog2(MAX_STOPS);
  localparam int STOP_CNT_W    = $clog2(MAX_STOPS + 1);
  localparam int STOP_W        = 49;

  // Configuration port
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_DURATION   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_0     = 3'd3;

  localparam logic [15:0] DURATION_RESET = 16'd1000;
  localparam logic [31:0] ONE_Q16        = 32'h0001_0000;

  // Shared divider
  localparam int DIV_STEPS_W = 6;
  localparam logic [DIV_STEPS_W-1:0] INC_STEPS = 6'd32;
  localparam logic [DIV_STEPS_W-1:0] CH_STEPS  = 6'd8;

  typedef struct packed {
    logic start_inc;  // start the increment division with the accepted delta
    logic phase_upd;  // fold the increment into phase and loop count
    logic scan_init;  // restart the stop scan
    logic scan_step;  // look at one stop
    logic ch_start;   // form one channel's numerator and start its division
    logic ch_store;   // take the channel quotient
    logic out_load;   // move the finished color to the output register
  } gca_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic scan_done;
    logic scan_blend;
    logic ch_last;
    logic out_free;
  } gca_status_t;

endpackage

`default_nettype wire

FILE: hdl/gradient_color_animator.sv
// Top level of the gradient color animator: controller, datapath and configuration port.
`default_nettype none

// Each tick transaction carries delta_t in ms; the block adds delta_t/duration_ms (Q16.16)
// to its phase, wraps or finishes a loop, and returns one ARGB color, blended between two
// stops where needed, plus the running flag. A tick runs the 32-step iterative division of
// the phase increment and its fold into the phase, scans the color stops one at a time,
// then, when two stops are blended, runs four channel divisions on the same shared divider
// (numerator, 8 steps, store), and finally loads the output register. A tick is accepted
// whenever the controller is idle, even while the previous result still waits in the output
// register. Configuration writes are always ready and must only be issued between ticks.
module gradient_color_animator (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [gca_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [gca_pkg::STOP_W-1:0]     cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [15:0]                    delta_t,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                running,
  output logic [7:0]                          alpha,
  output logic [7:0]                          red,
  output logic [7:0]                          green,
  output logic [7:0]                          blue
);
  import gca_pkg::*;

  gca_cmd_t    cmd;
  gca_status_t status;

  assign cfg_ready = 1'b1;

  gca_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  gca_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .delta_t   (delta_t),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .running   (running),
    .alpha     (alpha),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

endmodule

`default_nettype wire

FILE: hdl/gca_divider.sv
// Iterative restoring divider, one quotient bit per cycle, 16-bit divisor.
`default_nettype none

module gca_divider (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire logic [31:0]                        dividend,
  input  wire logic [15:0]                        rem_init,
  input  wire logic [gca_pkg::DIV_STEPS_W-1:0]    steps,
  input  wire logic [15:0]                        divisor,
  output logic                                    busy,
  output logic [31:0]                             quotient
);
  import gca_pkg::*;

  logic [15:0]            rem;
  logic [15:0]            dvs;
  logic [DIV_STEPS_W-1:0] cnt;
  logic [16:0]            shifted;
  logic [16:0]            trial;

  // Dividend bits shift out at the top while quotient bits shift in at the bottom
  assign shifted = {rem, quotient[31]};
  assign trial   = shifted - {1'b0, dvs};
  assign busy    = (cnt != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= steps;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= rem_init;
      quotient <= dividend;
      dvs      <= divisor;
    end else if (busy) begin
      if (!trial[16]) begin
        rem      <= trial[15:0];
        quotient <= {quotient[30:0], 1'b1};
      end else begin
        rem      <= shifted[15:0];
        quotient <= {quotient[30:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/gca_datapath.sv
// Datapath: configuration registers, phase accumulator, stop scan, channel blend, output register.
`default_nettype none

module gca_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  input  wire logic [gca_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [gca_pkg::STOP_W-1:0]      cfg_data,
  input  wire logic [15:0]                     delta_t,
  input  wire logic                            out_stall,
  input  wire gca_pkg::gca_cmd_t               cmd,
  output gca_pkg::gca_status_t                 status,
  output logic                                 out_valid,
  output logic                                 running,
  output logic [7:0]                           alpha,
  output logic [7:0]                           red,
  output logic [7:0]                           green,
  output logic [7:0]                           blue
);
  import gca_pkg::*;

  // Configuration
  logic [15:0]           duration_ms;
  logic [2:0]            stop_count;
  logic [STOP_W-1:0]     stops [MAX_STOPS];
  logic [CFG_IDX_W-1:0]  stop_sel;

  // Animation state
  logic [31:0]           phase_acc;
  logic [7:0]            loops_left;
  logic                  run_flag;

  // Scan and blend
  logic [STOP_CNT_W-1:0] k;
  logic [STOP_CNT_W-1:0] n_eff;
  logic [15:0]           prev_pos;
  logic [31:0]           prev_col;
  logic [STOP_W-1:0]     cur;
  logic [15:0]           cur_pos;
  logic [31:0]           cur_col;
  logic                  at_end;
  logic                  above;
  logic [15:0]           blend_d;
  logic [15:0]           blend_num;
  logic [31:0]           ca;
  logic [31:0]           cb;
  logic [31:0]           col;
  logic [1:0]            ch;
  logic [23:0]           prod_a;
  logic [23:0]           prod_b;
  logic [23:0]           numer;

  // Phase step
  logic [15:0]           dur_eff;
  logic [32:0]           sum;
  logic [31:0]           sat;

  // Divider hookup
  logic                  div_busy;
  logic [31:0]           quo;
  logic [31:0]           div_dividend;
  logic [15:0]           div_rem_init;
  logic [DIV_STEPS_W-1:0] div_steps;
  logic [15:0]           div_divisor;

  assign stop_sel = cfg_index - REG_STOP_0;

  always_ff @(posedge clk) begin
    if (rst) begin
      duration_ms <= DURATION_RESET;
      stop_count  <= '0;
      for (int i = 0; i < MAX_STOPS; i++) begin
        stops[i] <= '0;
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DURATION:   duration_ms <= cfg_data[15:0];
        REG_STOP_COUNT: stop_count  <= cfg_data[2:0];
        default: begin
          if (cfg_index >= REG_STOP_0 && stop_sel < 3'(STOP_REGS)) begin
            stops[stop_sel[STOP_IDX_W-1:0]] <= cfg_data;
          end
        end
      endcase
    end
  end

  // Increment division and phase fold
  assign dur_eff = (duration_ms == '0) ? 16'd1 : duration_ms;
  assign sum     = {1'b0, phase_acc} + {1'b0, quo};
  assign sat     = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc  <= '0;
      loops_left <= '0;
      run_flag   <= 1'b1;
    end else if (cfg_valid && cfg_index == REG_LOOP_COUNT) begin
      loops_left <= cfg_data[7:0];
    end else if (cmd.phase_upd) begin
      if (sat > ONE_Q16) begin
        if (loops_left == 8'd1) begin
          // final pass: phase held past 1.0
          phase_acc <= sat;
          run_flag  <= 1'b0;
        end else begin
          phase_acc <= {16'h0, sat[15:0]};
          run_flag  <= 1'b1;
          if (loops_left > 8'd1) begin
            loops_left <= loops_left - 8'd1;
          end
        end
      end else begin
        phase_acc <= sat;
        run_flag  <= 1'b1;
      end
    end
  end

  // Stop scan: one stop per cycle
  always_comb begin
    if (int'(stop_count) < MAX_STOPS) begin
      n_eff = STOP_CNT_W'(stop_count);
    end else begin
      n_eff = STOP_CNT_W'(MAX_STOPS);
    end
  end

  assign cur     = stops[k[STOP_IDX_W-1:0]];
  assign cur_pos = cur[47:32];
  assign cur_col = cur[31:0];
  assign at_end  = (k == n_eff);
  assign above   = ({16'h0, cur_pos} > phase_acc);

  // Blend numerator for the channel at the top of ca/cb
  assign prod_a = {16'h0, ca[31:24]} * {8'h0, blend_d - blend_num};
  assign prod_b = {16'h0, cb[31:24]} * {8'h0, blend_num};
  assign numer  = prod_a + prod_b + {9'h0, blend_d[15:1]};

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      k <= '0;
    end else if (cmd.scan_step) begin
      if (at_end) begin
        col <= (n_eff == '0) ? 32'h0 : prev_col;
      end else if (above) begin
        if (k == '0) begin
          col <= cur_col;
        end else begin
          blend_d   <= cur_pos - prev_pos;
          blend_num <= phase_acc[15:0] - prev_pos;
          ca        <= prev_col;
          cb        <= cur_col;
          ch        <= '0;
        end
      end else begin
        prev_pos <= cur_pos;
        prev_col <= cur_col;
        k        <= k + 1'b1;
      end
    end else if (cmd.ch_store) begin
      col <= {col[23:0], quo[7:0]};
      ca  <= {ca[23:0], 8'h0};
      cb  <= {cb[23:0], 8'h0};
      ch  <= ch + 2'd1;
    end
  end

  // One divider serves the increment and the four channel quotients
  always_comb begin
    if (cmd.start_inc) begin
      div_dividend = {delta_t, 16'h0};
      div_rem_init = '0;
      div_steps    = INC_STEPS;
      div_divisor  = dur_eff;
    end else begin
      // numerator is below 256*d, so the top part already fits as remainder
      div_dividend = {numer[7:0], 24'h0};
      div_rem_init = numer[23:8];
      div_steps    = CH_STEPS;
      div_divisor  = blend_d;
    end
  end

  gca_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.start_inc | cmd.ch_start),
    .dividend (div_dividend),
    .rem_init (div_rem_init),
    .steps    (div_steps),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (quo)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      running <= run_flag;
      alpha   <= col[31:24];
      red     <= col[23:16];
      green   <= col[15:8];
      blue    <= col[7:0];
    end
  end

  always_comb begin
    status            = '0;
    status.div_busy   = div_busy;
    status.scan_done  = at_end || above;
    status.scan_blend = !at_end && above && (k != '0);
    status.ch_last    = (ch == 2'd3);
    status.out_free   = !out_valid || !out_stall;
  end

endmodule

`default_nettype wire

FILE: hdl/gca_ctrl.sv
// Controller: sequences divide, phase update, stop scan, channel blend and output.
`default_nettype none

module gca_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire gca_pkg::gca_status_t  status,
  output gca_pkg::gca_cmd_t          cmd
);
  import gca_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_INC,
    S_SCAN,
    S_MUL,
    S_DIV_CH,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start_inc = 1'b1;
          state_next    = S_DIV_INC;
        end
      end
      S_DIV_INC: begin
        if (!status.div_busy) begin
          cmd.phase_upd = 1'b1;
          cmd.scan_init = 1'b1;
          state_next    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_done) begin
          state_next = status.scan_blend ? S_MUL : S_EMIT;
        end
      end
      S_MUL: begin
        cmd.ch_start = 1'b1;
        state_next   = S_DIV_CH;
      end
      S_DIV_CH: begin
        if (!status.div_busy) begin
          cmd.ch_store = 1'b1;
          state_next   = status.ch_last ? S_EMIT : S_MUL;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

FILE: bench/tb.sv
// Self-checking testbench for the gradient color animator: predicted ARGB colors vs. the block.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gca_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  typedef enum logic [1:0] {PLAN_TICK, PLAN_WRITE, PLAN_DRAIN} plan_kind_t;

  typedef struct packed {
    plan_kind_t            kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [STOP_W-1:0]     data;
    logic [15:0]           dt;
  } plan_t;

  typedef struct packed {
    logic       running;
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [STOP_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [15:0]          delta_t = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 running;
  logic [7:0]           alpha, red, green, blue;

  // predictor copy of the registers and animation state
  logic [15:0]       duration_ms;
  logic [2:0]        stop_count;
  logic [STOP_W-1:0] stop_regs [MAX_STOPS];
  logic [31:0]       phase_acc;
  logic [7:0]        loops_left;

  plan_t  tick_plan [$];
  color_t expected_colors [$];
  int     planned_ticks = 0;
  int     mismatches = 0;
  int     cycle_count = 0;
  int     send_gap = 0;
  int     recv_wait = 0;
  bit     send_calm = 1'b0;
  bit     recv_calm = 1'b0;

  gradient_color_animator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .delta_t   (delta_t),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .running   (running),
    .alpha     (alpha),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [STOP_W-1:0] data);
    case (idx)
      REG_DURATION: duration_ms = data[15:0];
      REG_LOOP_COUNT: begin
        loops_left = data[7:0];
      end
      REG_STOP_COUNT: stop_count = data[2:0];
      default: begin
        if (idx >= REG_STOP_0 && int'(idx) < int'(REG_STOP_0) + STOP_REGS)
          stop_regs[int'(idx) - int'(REG_STOP_0)] = data;
      end
    endcase
  endfunction

  // advance the phase by one tick and blend the color at the new phase
  function automatic color_t next_color(input logic [15:0] dt);
    logic [15:0] dur;
    logic [31:0] inc, col, ca, cb, p0, p1, d, num;
    logic [32:0] sum;
    logic [47:0] v;
    logic        run;
    int          n, i, ch;
    color_t      r;
    dur = (duration_ms == 16'd0) ? 16'd1 : duration_ms;
    inc = {dt, 16'h0000} / dur;
    sum = {1'b0, phase_acc} + {1'b0, inc};
    phase_acc = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    run = 1'b1;
    if (phase_acc > ONE_Q16) begin
      if (loops_left == 8'd1) begin
        run = 1'b0;  // final pass: hold the phase where it is
      end else begin
        phase_acc = phase_acc & 32'h0000_FFFF;
        if (loops_left > 8'd1) loops_left = loops_left - 8'd1;
      end
    end
    n = (int'(stop_count) < MAX_STOPS) ? int'(stop_count) : MAX_STOPS;
    col = '0;
    if (n > 0) begin
      i = 0;
      while (i < n && {16'h0000, stop_regs[i][47:32]} <= phase_acc) i++;
      if (i == n) begin
        col = stop_regs[n-1][31:0];
      end else if (i == 0) begin
        col = stop_regs[0][31:0];
      end else begin
        p0 = {16'h0000, stop_regs[i-1][47:32]};
        p1 = {16'h0000, stop_regs[i][47:32]};
        d = p1 - p0;
        num = phase_acc - p0;
        ca = stop_regs[i-1][31:0];
        cb = stop_regs[i][31:0];
        for (ch = 0; ch < 4; ch++) begin
          v = (ca[ch*8 +: 8] * (d - num) + cb[ch*8 +: 8] * num + d / 2) / d;
          if (v > 48'd255) v = 48'd255;
          col[ch*8 +: 8] = v[7:0];
        end
      end
    end
    r.running = run;
    r.alpha = col[31:24];
    r.red = col[23:16];
    r.green = col[15:8];
    r.blue = col[7:0];
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic plan_tick(input logic [15:0] dt);
    plan_t p;
    p = '{kind: PLAN_TICK, idx: '0, data: '0, dt: dt};
    tick_plan.push_back(p);
    planned_ticks++;
  endtask

  task automatic plan_drain();
    plan_t p;
    p = '{kind: PLAN_DRAIN, idx: '0, data: '0, dt: '0};
    tick_plan.push_back(p);
  endtask

  task automatic plan_write(input logic [CFG_IDX_W-1:0] idx, input logic [STOP_W-1:0] data);
    plan_t p;
    p = '{kind: PLAN_WRITE, idx: idx, data: data, dt: '0};
    tick_plan.push_back(p);
  endtask

  // settle the block, then rewrite every register
  task automatic plan_setup(input logic [15:0] dur, input logic [7:0] loops,
                            input logic [2:0] cnt, input logic [STOP_W-1:0] s0,
                            input logic [STOP_W-1:0] s1, input logic [STOP_W-1:0] s2,
                            input logic [STOP_W-1:0] s3);
    plan_drain();
    plan_write(REG_DURATION, STOP_W'(dur));
    plan_write(REG_LOOP_COUNT, STOP_W'(loops));
    plan_write(REG_STOP_COUNT, STOP_W'(cnt));
    plan_write(REG_STOP_0, s0);
    plan_write(REG_STOP_0 + 3'd1, s1);
    plan_write(REG_STOP_0 + 3'd2, s2);
    plan_write(REG_STOP_0 + 3'd3, s3);
  endtask

  always @(posedge clk) begin : drive
    logic  iv, cv;
    plan_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      cfg_valid <= 1'b0;
      duration_ms = DURATION_RESET;
      stop_count = '0;
      for (int k = 0; k < MAX_STOPS; k++) stop_regs[k] = '0;
      phase_acc = '0;
      loops_left = '0;
      send_gap = 0;
    end else begin
      iv = in_valid;
      cv = cfg_valid;
      if (in_valid && !in_stall) begin
        expected_colors.push_back(next_color(delta_t));
        iv = 1'b0;
        if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
        send_gap = send_calm ? 0 : $urandom_range(0, 19);
      end
      if (cfg_valid && cfg_ready) begin
        apply_reg_write(cfg_index, cfg_data);
        cv = 1'b0;
      end
      if (!iv && !cv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (tick_plan.size() != 0) begin
          nxt = tick_plan[0];
          case (nxt.kind)
            PLAN_TICK: begin
              delta_t <= nxt.dt;
              iv = 1'b1;
              void'(tick_plan.pop_front());
            end
            PLAN_WRITE: begin
              cfg_index <= nxt.idx;
              cfg_data <= nxt.data;
              cv = 1'b1;
              void'(tick_plan.pop_front());
            end
            default: begin
              // hold off until every outstanding color is back
              if (expected_colors.size() == 0) begin
                void'(tick_plan.pop_front());
                send_gap = 8;
              end
            end
          endcase
        end
      end
      in_valid <= iv;
      cfg_valid <= cv;
    end
  end

  always @(posedge clk) begin : watch
    color_t want;
    if (rst) begin
      out_stall <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_colors.size() == 0) begin
          $error("color transaction with no expected color pending");
          mismatches++;
        end else begin
          want = expected_colors.pop_front();
          check_field("running", {7'd0, want.running}, {7'd0, running});
          check_field("alpha", want.alpha, alpha);
          check_field("red", want.red, red);
          check_field("green", want.green, green);
          check_field("blue", want.blue, blue);
        end
        if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
        recv_wait = recv_calm ? 0 : $urandom_range(0, 19);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : plan
    logic [15:0]       dur, dt, tmp;
    logic [7:0]        loops;
    logic [2:0]        cnt;
    logic [15:0]       pos [4];
    logic [STOP_W-1:0] st [4];
    int                len, k, j, r;

    // reset configuration: empty table, endless looping
    plan_tick(16'd0);
    plan_tick(16'hFFFF);
    plan_tick(16'd1);
    // zero duration on the final pass: phase held, then saturates
    plan_setup(16'd0, 8'd1, 3'd4, {1'b0, 16'h0000, 32'h0000_0000},
               {1'b1, 16'h5555, 32'hFFFF_FFFF}, {1'b0, 16'hAAAA, 32'h00FF_00FF},
               {1'b0, 16'hFFFF, 32'hFF00_FF00});
    plan_tick(16'd1);
    plan_tick(16'hFFFF);
    plan_tick(16'hFFFF);
    plan_tick(16'd0);
    // stop count beyond the table, ignored top bit, blends across all stops
    plan_setup(16'hFFFF, 8'd3, 3'd7, {1'b1, 16'h0000, 32'hFFFF_FFFF},
               {1'b0, 16'h4000, 32'h0000_0000}, {1'b1, 16'h8000, 32'h80FF_0180},
               {1'b0, 16'hC000, 32'h1234_5678});
    plan_tick(16'd0);
    plan_tick(16'd8192);
    plan_tick(16'd16384);
    plan_tick(16'd24575);
    plan_tick(16'd32768);
    plan_tick(16'hFFFF);
    plan_tick(16'd40000);
    // single stop: the phase stays below it, across one loop wrap
    plan_setup(16'd1000, 8'd2, 3'd1, {1'b0, 16'h8000, 32'hDEAD_BEEF}, '0, '0, '0);
    plan_tick(16'd100);
    plan_tick(16'd400);
    plan_tick(16'd700);
    // two stops near the ends, longest duration, many loops
    plan_setup(16'hFFFF, 8'd255, 3'd2, {1'b0, 16'h0001, 32'h0102_0304},
               {1'b0, 16'hFFFE, 32'hFCFD_FEFF}, '0, '0);
    plan_tick(16'd32767);
    plan_tick(16'd1);
    plan_tick(16'd65534);

    while (planned_ticks < 1350) begin
      r = $urandom_range(0, 9);
      if (r == 0) dur = 16'd0;
      else if (r == 1) dur = 16'hFFFF;
      else if (r < 5) dur = 16'($urandom_range(1, 64));
      else dur = 16'($urandom_range(1, 65535));
      r = $urandom_range(0, 9);
      if (r < 4) loops = 8'd0;
      else if (r < 8) loops = 8'($urandom_range(1, 4));
      else if (r == 8) loops = 8'd255;
      else loops = 8'($urandom);
      r = $urandom_range(0, 9);
      if (r == 0) cnt = 3'd0;
      else if (r == 1) cnt = 3'd1;
      else if (r < 8) cnt = 3'($urandom_range(2, 4));
      else cnt = 3'($urandom_range(5, 7));
      for (k = 0; k < 4; k++) pos[k] = 16'($urandom_range(0, 65535));
      if ($urandom_range(0, 3) == 0) begin
        pos[0] = 16'h0000;
        pos[3] = 16'hFFFF;
      end
      // mostly ascending positions; now and then left unsorted
      if ($urandom_range(0, 7) != 0) begin
        for (k = 0; k < 3; k++)
          for (j = 0; j < 3 - k; j++)
            if (pos[j] > pos[j+1]) begin
              tmp = pos[j];
              pos[j] = pos[j+1];
              pos[j+1] = tmp;
            end
      end
      for (k = 0; k < 4; k++)
        st[k] = {1'($urandom_range(0, 1)), pos[k], 32'($urandom)};
      plan_setup(dur, loops, cnt, st[0], st[1], st[2], st[3]);
      len = $urandom_range(10, 60);
      for (k = 0; k < len; k++) begin
        if ($urandom_range(0, 3) == 0)
          dt = 16'($urandom_range(0, 65535));
        else
          dt = 16'($urandom_range(0, int'(dur) / 3 + 1));
        plan_tick(dt);
        if ($urandom_range(0, 49) == 0) plan_drain();
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (tick_plan.size() != 0 || in_valid || cfg_valid) @(posedge clk);
    while (expected_colors.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire
